>>> src/assert_macros.svh
// Assertion macros for the block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wsd_pkg.sv
// Package: shared types, constants and tables for the waypoint steering block.
package wsd_pkg;

  localparam int CordicIterDefault = 16;
  localparam int unsigned DegBamK = 32'd1281023894;
  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam int DxScale = 72955;
  localparam int DyScale = 72443;
  localparam logic [23:0] DistMax = 24'hFFFFFF;

  localparam logic [2:0] DirIdle  = 3'd0;
  localparam logic [2:0] DirRight = 3'd1;
  localparam logic [2:0] DirLeft  = 3'd2;
  localparam logic [2:0] DirFront = 3'd3;
  localparam logic [2:0] DirStop  = 3'd4;

  localparam logic [0:0] CfgDeadband = 1'b0;
  localparam logic [0:0] CfgArrive   = 1'b1;

  // Datapath operation codes
  typedef enum logic [3:0] {
    OP_LOAD,     // latch request fields, compute deltas
    OP_BAM_SEL,  // select angle source and take magnitude
    OP_BAM_MUL,  // magnitude times conversion constant
    OP_ROT_INIT, // fold angle, init rotation CORDIC
    OP_ROT_STEP, // one rotation iteration
    OP_ROT_DONE, // store sin/cos
    OP_PROD,     // one scaled product step
    OP_VEC_INIT, // init vectoring CORDIC
    OP_VEC_STEP, // one vectoring iteration
    OP_BEARING,  // convert angle to centidegrees
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DECIDE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;   // angle source / sin-cos store index
    logic [3:0] psel;  // product step select
  } dp_cmd_t;

  typedef struct packed {
    logic last_iter;   // CORDIC counter reached the end
    logic sqrt_done;   // root finished
  } dp_sts_t;

  function automatic logic signed [31:0] atan_bam(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> src/waypoint_steering_decision.sv
// Waypoint steering decision: a tick while armed gives its result once the shared CORDIC
// unit has run the three sin/cos rotations and the atan2 vectoring in turn, then a 32-step
// square root. A target request or a tick while disarmed answers in the cycle after it is
// accepted. One request is in work at a time; a result waits in the output register.
module waypoint_steering_decision import wsd_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         in_opcode,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [15:0] in_heading,
  input  logic [0:0]         in_heading_fresh,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_direction,
  output logic [23:0]        out_distance_cm,
  output logic signed [16:0] out_turn_angle
);
`include "assert_macros.svh"

  logic [14:0]        deadband_r;
  logic [23:0]        arrive_r;
  logic               active_r, busy_r;
  logic signed [30:0] tlat_r;
  logic signed [31:0] tlon_r;
  logic signed [30:0] clat_r;
  logic signed [31:0] clon_r;
  logic signed [15:0] head_r;
  logic               ov_r;
  logic [2:0]         odir_r;
  logic [23:0]        odist_r;
  logic signed [16:0] oturn_r;
  logic               acc, start, done;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [2:0]         dir;
  logic [23:0]        dp_dist;
  logic signed [16:0] turn;

  assign in_ready = !busy_r && !ov_r;
  assign acc = in_valid && in_ready;
  assign start = acc && in_opcode == 1'b1 && active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= 15'd300; arrive_r <= 24'd500; active_r <= 1'b0;
      busy_r <= 1'b0; ov_r <= 1'b0; tlat_r <= '0; tlon_r <= '0; head_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CfgDeadband) deadband_r <= cfg_data[14:0];
      if (cfg_we && cfg_index == CfgArrive) arrive_r <= cfg_data;
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (acc) begin
        if (in_opcode == 1'b0) begin
          tlat_r <= in_latitude; tlon_r <= in_longitude; active_r <= 1'b1;
          ov_r <= 1'b1; odir_r <= DirIdle; odist_r <= '0; oturn_r <= '0;
        end else if (!active_r) begin
          ov_r <= 1'b1; odir_r <= DirIdle; odist_r <= '0; oturn_r <= '0;
        end else begin
          busy_r <= 1'b1;
          clat_r <= in_latitude; clon_r <= in_longitude;
          if (in_heading_fresh == 1'b1) head_r <= in_heading;
        end
      end
      if (done) begin
        busy_r <= 1'b0; ov_r <= 1'b1;
        odir_r <= dir; odist_r <= dp_dist; oturn_r <= turn;
        if (dir == DirFront) active_r <= 1'b0;
      end
    end
  end

  wsd_ctrl u_ctrl (.clk, .rst_n, .start, .sts, .cmd, .done);

  wsd_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_latitude(clat_r), .in_longitude(clon_r),
    .tgt_lat(tlat_r), .tgt_lon(tlon_r), .heading(head_r),
    .turn_deadband(deadband_r), .arrive_distance(arrive_r),
    .direction(dir), .distance_cm(dp_dist), .turn_angle(turn)
  );

  assign out_valid       = ov_r;
  assign out_direction   = odir_r;
  assign out_distance_cm = odist_r;
  assign out_turn_angle  = oturn_r;

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, busy_r, !ov_r, "result pending while busy")
  `ASSERT_NEXT(a_done_out, clk, rst_n, done, ov_r, "finished tick left no result")
  `ASSERT_IMPL(a_front_disarm, clk, rst_n, done && dir == DirFront, busy_r, "front outside a tick")

endmodule

>>> src/wsd_datapath.sv
// Datapath: shared CORDIC unit, product unit, square root and decision.
module wsd_datapath import wsd_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic signed [30:0]  in_latitude,
  input  logic signed [31:0]  in_longitude,
  input  logic signed [30:0]  tgt_lat,
  input  logic signed [31:0]  tgt_lon,
  input  logic signed [15:0]  heading,
  input  logic [14:0]         turn_deadband,
  input  logic [23:0]         arrive_distance,
  output logic [2:0]          direction,
  output logic [23:0]         distance_cm,
  output logic signed [16:0]  turn_angle
);

  localparam int IterN = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam logic [4:0] IterLast = 5'(IterN - 1);

  logic signed [30:0] lat_r;
  logic signed [32:0] dlon_r;
  logic signed [31:0] dlat_r;
  logic [32:0]        mag_r;
  logic               negv_r;
  logic [63:0]        prod_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               fneg_r;
  logic [4:0]         it_r;
  logic signed [31:0] s1_r, c1_r, s2_r, c2_r, sd_r, cd_r;
  logic signed [33:0] bx_r, by_r, tmp_r;
  logic signed [16:0] bear_r;
  logic signed [40:0] dx_r, dy_r;
  logic [63:0]        rem_r, root_r, bit_r;
  logic [23:0]        dist_r;
  logic [2:0]         dir_r;
  logic signed [16:0] turn_r;
  logic               sat_r;

  logic signed [32:0] src_v;
  logic [31:0]        bam_v;
  logic signed [33:0] sx_v, sy_v;
  logic signed [67:0] pm_v;
  logic signed [33:0] pa_v, pb_v;
  logic [63:0]        rb_v;
  logic signed [40:0] adx_v, ady_v;

  always_comb begin
    unique case (cmd.sel)
      2'd0:    src_v = 33'(lat_r);
      2'd1:    src_v = 33'(tgt_lat);
      default: src_v = dlon_r;
    endcase
    bam_v = 32'((prod_r + 64'd536870912) >> 30);
    if (negv_r) bam_v = 32'd0 - bam_v;
    sx_v = cx_r >>> it_r;
    sy_v = cy_r >>> it_r;
    unique case (cmd.psel)
      4'd0:    begin pa_v = 34'(sd_r); pb_v = 34'(c2_r); end
      4'd1:    begin pa_v = 34'(c1_r); pb_v = 34'(s2_r); end
      4'd2:    begin pa_v = 34'(s1_r); pb_v = 34'(c2_r); end
      4'd3:    begin pa_v = tmp_r;     pb_v = 34'(cd_r); end
      4'd4:    begin pa_v = 34'(dlon_r); pb_v = 34'(c1_r); end
      4'd5:    begin pa_v = tmp_r;     pb_v = 34'(DxScale); end
      default: begin pa_v = 34'(dlat_r); pb_v = 34'(DyScale); end
    endcase
    pm_v = pa_v * pb_v;
    rb_v = root_r + bit_r;
    adx_v = (dx_r < 0) ? -dx_r : dx_r;
    ady_v = (dy_r < 0) ? -dy_r : dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          lat_r  <= in_latitude;
          dlon_r <= 33'(tgt_lon) - 33'(in_longitude);
          dlat_r <= 32'(tgt_lat) - 32'(in_latitude);
        end
        OP_BAM_SEL: begin
          negv_r <= src_v[32];
          mag_r  <= src_v[32] ? 33'(-src_v) : 33'(src_v);
        end
        OP_BAM_MUL: prod_r <= 64'(mag_r) * 64'(DegBamK);
        OP_ROT_INIT: begin
          fneg_r <= (bam_v[31:30] == 2'd1) || (bam_v[31:30] == 2'd2);
          cz_r   <= ((bam_v[31:30] == 2'd1) || (bam_v[31:30] == 2'd2)) ?
                    34'(signed'(bam_v + 32'h80000000)) : 34'(signed'(bam_v));
          cx_r   <= 34'(GainQ30);
          cy_r   <= '0;
          it_r   <= '0;
        end
        OP_ROT_STEP: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - sy_v; cy_r <= cy_r + sx_v; cz_r <= cz_r - 34'(atan_bam(it_r));
          end else begin
            cx_r <= cx_r + sy_v; cy_r <= cy_r - sx_v; cz_r <= cz_r + 34'(atan_bam(it_r));
          end
          it_r <= it_r + 5'd1;
        end
        OP_ROT_DONE: begin
          unique case (cmd.sel)
            2'd0: begin
              s1_r <= 32'(fneg_r ? -cy_r : cy_r); c1_r <= 32'(fneg_r ? -cx_r : cx_r);
            end
            2'd1: begin
              s2_r <= 32'(fneg_r ? -cy_r : cy_r); c2_r <= 32'(fneg_r ? -cx_r : cx_r);
            end
            default: begin
              sd_r <= 32'(fneg_r ? -cy_r : cy_r); cd_r <= 32'(fneg_r ? -cx_r : cx_r);
            end
          endcase
        end
        OP_PROD: begin
          unique case (cmd.psel)
            4'd0: bx_r  <= 34'(pm_v >>> 30);
            4'd1: by_r  <= 34'(pm_v >>> 30);
            4'd2: tmp_r <= 34'(pm_v >>> 30);
            4'd3: by_r  <= by_r - 34'(pm_v >>> 30);
            4'd4: tmp_r <= 34'(pm_v >>> 30);
            4'd5: dx_r  <= 41'(pm_v >>> 12);
            default: dy_r <= 41'(pm_v >>> 12);
          endcase
        end
        OP_VEC_INIT: begin
          it_r <= '0;
          if (by_r < 0) begin
            cx_r <= -by_r; cy_r <= -bx_r; cz_r <= 34'sh080000000;
          end else begin
            cx_r <= by_r; cy_r <= bx_r; cz_r <= '0;
          end
        end
        OP_VEC_STEP: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + sy_v; cy_r <= cy_r - sx_v; cz_r <= cz_r + 34'(atan_bam(it_r));
          end else begin
            cx_r <= cx_r - sy_v; cy_r <= cy_r + sx_v; cz_r <= cz_r - 34'(atan_bam(it_r));
          end
          it_r <= it_r + 5'd1;
        end
        OP_BEARING: begin
          if (bx_r == 0 && by_r == 0) bear_r <= '0;
          else bear_r <= 17'(((64'(signed'(cz_r[31:0])) * 64'sd36000)
                              + 64'sd2147483648) >>> 32);
        end
        OP_SQRT_INIT: begin
          // below 2^28 on both axes the magnitudes fit 28 bits
          sat_r  <= (adx_v >= 41'sd268435456) || (ady_v >= 41'sd268435456);
          rem_r  <= 64'(adx_v[27:0] * adx_v[27:0]) + 64'(ady_v[27:0] * ady_v[27:0]);
          root_r <= '0;
          bit_r  <= 64'h4000000000000000;
        end
        OP_SQRT_STEP: begin
          if (bit_r != 0) begin
            if (rem_r >= rb_v) begin
              rem_r <= rem_r - rb_v; root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        default: begin
          turn_r <= bear_r + 17'(heading);
          dist_r <= (sat_r || ((root_r + 64'd8) >> 4) > 64'(DistMax)) ? DistMax :
                    24'((root_r + 64'd8) >> 4);
        end
      endcase
    end
  end

  always_comb begin
    if (turn_r > $signed({2'b0, turn_deadband})) dir_r = DirRight;
    else if (turn_r < -$signed({2'b0, turn_deadband})) dir_r = DirLeft;
    else if (dist_r > arrive_distance) dir_r = DirFront;
    else dir_r = DirStop;
  end

  assign sts.last_iter = (it_r == IterLast);
  assign sts.sqrt_done = (bit_r == 64'd0);
  assign direction   = dir_r;
  assign distance_cm = dist_r;
  assign turn_angle  = turn_r;

endmodule

>>> src/wsd_ctrl.sv
// Controller: sequences the datapath for one navigation tick.
module wsd_ctrl import wsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    done
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SEL, S_MUL, S_RINIT, S_RSTEP, S_RDONE, S_PROD,
    S_VINIT, S_VSTEP, S_BEAR, S_QINIT, S_QSTEP, S_DEC
  } state_t;

  state_t     state_r;
  logic [1:0] src_r;
  logic [3:0] pi_r;
  logic       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; src_r <= '0; pi_r <= '0; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE:  if (start) state_r <= S_LOAD;
        S_LOAD:  begin src_r <= '0; state_r <= S_SEL; end
        S_SEL:   state_r <= S_MUL;
        S_MUL:   state_r <= S_RINIT;
        S_RINIT: state_r <= S_RSTEP;
        S_RSTEP: if (sts.last_iter) state_r <= S_RDONE;
        S_RDONE: begin
          if (src_r == 2'd2) begin pi_r <= '0; state_r <= S_PROD; end
          else begin src_r <= src_r + 2'd1; state_r <= S_SEL; end
        end
        S_PROD: begin
          pi_r <= pi_r + 4'd1;
          if (pi_r == 4'd6) state_r <= S_VINIT;
        end
        S_VINIT: state_r <= S_VSTEP;
        S_VSTEP: if (sts.last_iter) state_r <= S_BEAR;
        S_BEAR:  state_r <= S_QINIT;
        S_QINIT: state_r <= S_QSTEP;
        S_QSTEP: if (sts.sqrt_done) state_r <= S_DEC;
        default: begin state_r <= S_IDLE; done_r <= 1'b1; end
      endcase
    end
  end

  always_comb begin
    cmd.sel = src_r; cmd.psel = pi_r;
    unique case (state_r)
      S_LOAD:  cmd.op = OP_LOAD;
      S_SEL:   cmd.op = OP_BAM_SEL;
      S_MUL:   cmd.op = OP_BAM_MUL;
      S_RINIT: cmd.op = OP_ROT_INIT;
      S_RSTEP: cmd.op = OP_ROT_STEP;
      S_RDONE: cmd.op = OP_ROT_DONE;
      S_PROD:  cmd.op = OP_PROD;
      S_VINIT: cmd.op = OP_VEC_INIT;
      S_VSTEP: cmd.op = OP_VEC_STEP;
      S_BEAR:  cmd.op = OP_BEARING;
      S_QINIT: cmd.op = OP_SQRT_INIT;
      S_QSTEP: cmd.op = OP_SQRT_STEP;
      S_DEC:   cmd.op = OP_DECIDE;
      default: cmd.op = OP_VEC_INIT;
    endcase
    if (state_r == S_IDLE) cmd.op = OP_DECIDE;
  end

  assign done = done_r;

endmodule
